@@ design/display_coprocessor_move_wait_skip_defines.svh @@
// Assertion macros shared by the display coprocessor RTL.
// Depends on nothing; included by the top level only.
`ifndef DISPLAY_COPROCESSOR_MOVE_WAIT_SKIP_DEFINES_SVH
`define DISPLAY_COPROCESSOR_MOVE_WAIT_SKIP_DEFINES_SVH

// Same-cycle implication under the synchronous active-low reset.
`define DCMWS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under the synchronous active-low reset.
`define DCMWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/dcmws_pkg.sv @@
// Shared types and constants of the display coprocessor.
// Depends on nothing; used by every module of the block.
package dcmws_pkg;

    // Program address width and the fixed widths of the ports.
    localparam int ADDRESS_BITS   = 21;
    localparam int FETCH_ADDR_W   = 21;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ADDRESS_BITS-1:0] t_addr;

    // Request codes of an input item.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_FRAME = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DANGER  = 2'd0;
    localparam logic [1:0] CFG_RESTART = 2'd1;
    localparam logic [1:0] CFG_DMA     = 2'd2;
    localparam logic [1:0] CFG_LINE    = 2'd3;

    localparam logic [7:0] LINE_CYCLES_RESET = 8'd227;

    // Instruction field constants.
    localparam logic [7:0] HPOS_MASK      = 8'hfe;
    localparam logic [7:0] VPOS_FORCE     = 8'h80;
    localparam logic [8:0] REG_MIN_SAFE   = 9'h080;
    localparam logic [8:0] REG_MIN_DANGER = 9'h040;

    // What the back end has to do with a queued item.
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_TICK = 2'd1,
        KIND_LOAD = 2'd2
    } t_kind;

    typedef struct packed {
        logic        danger_enable;
        logic [20:0] restart_pointer;
        logic        dma_enable;
        logic [7:0]  line_cycles;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        t_addr       pointer;
        logic [7:0]  line;
        logic [7:0]  cyc;
        logic [15:0] word;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic                    fetch_valid;
        logic [FETCH_ADDR_W-1:0] fetch_address;
        logic                    reg_write_valid;
        logic [8:0]              reg_address;
        logic [15:0]             reg_data;
        logic                    halted;
        logic                    waiting;
    } t_result;

endpackage

@@ design/dcmws_front.sv @@
// Front end: accepts input items and classifies them for the back end.
// Depends on dcmws_pkg.
module dcmws_front (
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_req_type,
    input  logic [8:0]              i_beam_line,
    input  logic [7:0]              i_beam_cycle,
    input  logic [15:0]             i_mem_word,
    input  logic [20:0]             i_new_pointer,
    input  dcmws_pkg::t_cfg         i_cfg,
    input  dcmws_pkg::t_queue_status i_queue_status,
    output logic                    o_push,
    output dcmws_pkg::t_item        o_item
);

    logic w_last_odd;

    // A slot tick on the odd last cycle of a line gets no copper action.
    assign w_last_odd = i_cfg.line_cycles[0] &&
                        (i_beam_cycle == (i_cfg.line_cycles - 8'd1));

    assign o_in_ready = !i_queue_status.full;
    assign o_push     = i_in_valid && !i_queue_status.full;

    // Classify the request and pick the restart address.
    always_comb begin
        o_item.line    = i_beam_line[7:0];
        o_item.cyc     = i_beam_cycle;
        o_item.word    = i_mem_word;
        o_item.pointer = dcmws_pkg::t_addr'(i_new_pointer);
        o_item.kind    = dcmws_pkg::KIND_NONE;
        unique case (i_req_type)
            dcmws_pkg::REQ_TICK: begin
                if (i_cfg.dma_enable && !w_last_odd) begin
                    o_item.kind = dcmws_pkg::KIND_TICK;
                end
            end
            dcmws_pkg::REQ_LOAD: begin
                o_item.kind = dcmws_pkg::KIND_LOAD;
            end
            dcmws_pkg::REQ_FRAME: begin
                o_item.kind    = dcmws_pkg::KIND_LOAD;
                o_item.pointer = dcmws_pkg::t_addr'(i_cfg.restart_pointer);
            end
            default: begin
                o_item.kind = dcmws_pkg::KIND_NONE;
            end
        endcase
    end

endmodule

@@ design/dcmws_queue.sv @@
// Short queue of classified items between the front and back ends.
// Depends on dcmws_pkg.
module dcmws_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  dcmws_pkg::t_item         i_item,
    input  logic                     i_pop,
    output dcmws_pkg::t_item         o_item,
    output dcmws_pkg::t_queue_status o_status
);

    dcmws_pkg::t_item                      r_mem [dcmws_pkg::QUEUE_DEPTH];
    logic [dcmws_pkg::QUEUE_PTR_W-1:0]     r_wr_ptr;
    logic [dcmws_pkg::QUEUE_PTR_W-1:0]     r_rd_ptr;
    logic [dcmws_pkg::QUEUE_CNT_W-1:0]     r_count;

    assign o_item         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == dcmws_pkg::QUEUE_CNT_W'(dcmws_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + dcmws_pkg::QUEUE_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + dcmws_pkg::QUEUE_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + dcmws_pkg::QUEUE_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - dcmws_pkg::QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

@@ design/dcmws_back.sv @@
// Back end: runs the MOVE/WAIT/SKIP sequencer and holds the output register.
// Depends on dcmws_pkg.
module dcmws_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  dcmws_pkg::t_cfg          i_cfg,
    input  dcmws_pkg::t_item         i_item,
    input  dcmws_pkg::t_queue_status i_queue_status,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output dcmws_pkg::t_result       o_result
);

    typedef enum logic [4:0] {
        PH_STOP   = 5'b00001,
        PH_FIRST  = 5'b00010,
        PH_SECOND = 5'b00100,
        PH_EXEC   = 5'b01000,
        PH_WAIT   = 5'b10000
    } t_phase;

    t_phase             r_phase, n_phase;
    dcmws_pkg::t_addr   r_pc, n_pc;
    logic [15:0]        r_fw, n_fw;
    logic [15:0]        r_sw, n_sw;
    logic               r_skip, n_skip;
    logic               r_out_valid;
    dcmws_pkg::t_result r_result, n_result;
    logic [8:0]         w_reg;
    logic               w_reg_ok;

    // True once the beam has reached the masked position of an instruction.
    function automatic logic beam_reached(input logic [15:0] fw, input logic [15:0] sw,
                                          input logic [7:0] line, input logic [7:0] cyc);
        logic [7:0] ve;
        logic [7:0] he;
        logic [7:0] ly;
        logic [7:0] ty;
        ve = sw[15:8] | dcmws_pkg::VPOS_FORCE;
        he = sw[7:0] & dcmws_pkg::HPOS_MASK;
        ly = line & ve;
        ty = fw[15:8] & ve;
        return (ly > ty) || ((ly == ty) && ((cyc & he) >= (fw[7:0] & he)));
    endfunction

    assign o_pop       = !i_queue_status.empty && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    // Register number of a MOVE and its legality.
    assign w_reg    = {r_fw[8:1], 1'b0};
    assign w_reg_ok = (w_reg >= dcmws_pkg::REG_MIN_SAFE) ||
                      ((w_reg >= dcmws_pkg::REG_MIN_DANGER) && i_cfg.danger_enable);

    // Sequencer step for the item at the head of the queue.
    always_comb begin
        n_phase  = r_phase;
        n_pc     = r_pc;
        n_fw     = r_fw;
        n_sw     = r_sw;
        n_skip   = r_skip;
        n_result = '0;
        unique case (i_item.kind)
            dcmws_pkg::KIND_LOAD: begin
                n_pc    = i_item.pointer;
                n_skip  = 1'b0;
                n_phase = PH_FIRST;
            end
            dcmws_pkg::KIND_TICK: begin
                unique case (r_phase)
                    PH_FIRST: begin
                        n_result.fetch_valid   = 1'b1;
                        n_result.fetch_address = dcmws_pkg::FETCH_ADDR_W'(r_pc);
                        n_pc    = r_pc + dcmws_pkg::t_addr'(2);
                        n_phase = PH_SECOND;
                    end
                    PH_SECOND: begin
                        n_fw = i_item.word;
                        n_result.fetch_valid   = 1'b1;
                        n_result.fetch_address = dcmws_pkg::FETCH_ADDR_W'(r_pc);
                        n_pc    = r_pc + dcmws_pkg::t_addr'(2);
                        n_phase = PH_EXEC;
                    end
                    PH_EXEC: begin
                        n_sw = i_item.word;
                        if (!r_fw[0]) begin
                            // MOVE: an illegal register stops the program.
                            if (!w_reg_ok) begin
                                n_phase = PH_STOP;
                                n_skip  = 1'b0;
                            end else begin
                                if (!r_skip) begin
                                    n_result.reg_write_valid = 1'b1;
                                    n_result.reg_address     = w_reg;
                                    n_result.reg_data        = i_item.word;
                                end
                                n_skip = 1'b0;
                                n_result.fetch_valid   = 1'b1;
                                n_result.fetch_address = dcmws_pkg::FETCH_ADDR_W'(r_pc);
                                n_pc    = r_pc + dcmws_pkg::t_addr'(2);
                                n_phase = PH_SECOND;
                            end
                        end else if (!i_item.word[0]) begin
                            // WAIT: hold until the beam position is reached.
                            n_skip  = 1'b0;
                            n_phase = PH_WAIT;
                        end else begin
                            // SKIP: arm the flag if the position has been passed.
                            n_skip = beam_reached(r_fw, i_item.word, i_item.line, i_item.cyc);
                            n_result.fetch_valid   = 1'b1;
                            n_result.fetch_address = dcmws_pkg::FETCH_ADDR_W'(r_pc);
                            n_pc    = r_pc + dcmws_pkg::t_addr'(2);
                            n_phase = PH_SECOND;
                        end
                    end
                    PH_WAIT: begin
                        if (beam_reached(r_fw, r_sw, i_item.line, i_item.cyc)) begin
                            n_result.fetch_valid   = 1'b1;
                            n_result.fetch_address = dcmws_pkg::FETCH_ADDR_W'(r_pc);
                            n_pc    = r_pc + dcmws_pkg::t_addr'(2);
                            n_phase = PH_SECOND;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        n_result.halted  = (n_phase == PH_STOP);
        n_result.waiting = (n_phase == PH_WAIT);
    end

    // Sequencer state, updated once per popped item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_STOP;
            r_pc    <= '0;
            r_fw    <= '0;
            r_sw    <= '0;
            r_skip  <= 1'b0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_pc    <= n_pc;
            r_fw    <= n_fw;
            r_sw    <= n_sw;
            r_skip  <= n_skip;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

endmodule

@@ design/display_coprocessor_move_wait_skip.sv @@
// Path: an accepted item is first registered in the queue, then its result in the output
// register, where it is held until it is taken.
// Throughput: one item per cycle; input ready drops only when the two-entry queue is full.
// Reset: program stopped, counter, instruction words, skip flag and queue cleared;
// registers at danger_enable 0, restart_pointer 0, dma_enable 0, line_cycles 227.
// Depends on dcmws_pkg, dcmws_front, dcmws_queue, dcmws_back and the defines header.
`include "display_coprocessor_move_wait_skip_defines.svh"

module display_coprocessor_move_wait_skip (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [8:0]  i_beam_line,
    input  logic [7:0]  i_beam_cycle,
    input  logic [15:0] i_mem_word,
    input  logic [20:0] i_new_pointer,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_fetch_valid,
    output logic [20:0] o_fetch_address,
    output logic        o_reg_write_valid,
    output logic [8:0]  o_reg_address,
    output logic [15:0] o_reg_data,
    output logic        o_halted,
    output logic        o_waiting,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    dcmws_pkg::t_cfg          r_cfg;
    dcmws_pkg::t_item         w_front_item;
    dcmws_pkg::t_item         w_queue_item;
    dcmws_pkg::t_queue_status w_queue_status;
    dcmws_pkg::t_result       w_result;
    logic                     w_push;
    logic                     w_pop;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.danger_enable   <= 1'b0;
            r_cfg.restart_pointer <= '0;
            r_cfg.dma_enable      <= 1'b0;
            r_cfg.line_cycles     <= dcmws_pkg::LINE_CYCLES_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dcmws_pkg::CFG_DANGER:  r_cfg.danger_enable   <= i_cfg_data[0];
                dcmws_pkg::CFG_RESTART: r_cfg.restart_pointer <= i_cfg_data[20:0];
                dcmws_pkg::CFG_DMA:     r_cfg.dma_enable      <= i_cfg_data[0];
                dcmws_pkg::CFG_LINE:    r_cfg.line_cycles     <= i_cfg_data[7:0];
                default:                r_cfg.dma_enable      <= r_cfg.dma_enable;
            endcase
        end
    end

    // Front end: accept and classify.
    dcmws_front u_front (
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_beam_line    (i_beam_line),
        .i_beam_cycle   (i_beam_cycle),
        .i_mem_word     (i_mem_word),
        .i_new_pointer  (i_new_pointer),
        .i_cfg          (r_cfg),
        .i_queue_status (w_queue_status),
        .o_push         (w_push),
        .o_item         (w_front_item)
    );

    // Queue between the two ends.
    dcmws_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_front_item),
        .i_pop    (w_pop),
        .o_item   (w_queue_item),
        .o_status (w_queue_status)
    );

    // Back end: sequencer and output register.
    dcmws_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_item         (w_queue_item),
        .i_queue_status (w_queue_status),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result       (w_result)
    );

    assign o_fetch_valid     = w_result.fetch_valid;
    assign o_fetch_address   = w_result.fetch_address;
    assign o_reg_write_valid = w_result.reg_write_valid;
    assign o_reg_address     = w_result.reg_address;
    assign o_reg_data        = w_result.reg_data;
    assign o_halted          = w_result.halted;
    assign o_waiting         = w_result.waiting;

    // A register write always targets an even, legal offset and comes with the next fetch.
    `DCMWS_ASSERT_NOW(a_write_legal, i_clk, i_rst_n, o_out_valid && o_reg_write_valid,
        !o_reg_address[0] && (o_reg_address[8:6] != 3'd0) && o_fetch_valid,
        "register write to an illegal offset or without a fetch")
    // A stopped or waiting sequencer issues nothing in that item.
    `DCMWS_ASSERT_NOW(a_idle_quiet, i_clk, i_rst_n, o_out_valid && (o_halted || o_waiting),
        !o_fetch_valid && !o_reg_write_valid && !(o_halted && o_waiting),
        "activity while stopped or waiting")
    // An item in the queue is never lost: when the output is free it moves on next cycle.
    `DCMWS_ASSERT_NEXT(a_queue_drains, i_clk, i_rst_n, !w_queue_status.empty && !o_out_valid,
        o_out_valid, "queued item not delivered to the output register")

endmodule

@@ tb/slot_scoreboard_pkg.sv @@
// Scoreboard for the display coprocessor: a slot-by-slot predictor and the result check.
// Depends on dcmws_pkg for the request codes, register indexes and the result layout.
package slot_scoreboard_pkg;
    import dcmws_pkg::*;

    // Sequencer states of the predictor.
    typedef enum logic [2:0] {
        SEQ_STOP   = 3'd0,
        SEQ_FIRST  = 3'd1,
        SEQ_SECOND = 3'd2,
        SEQ_EXEC   = 3'd3,
        SEQ_WAIT   = 3'd4
    } seq_phase_e;

    localparam int MAX_PRINTED = 40;

    class slot_scoreboard;
        // Configuration as last written.
        bit          danger_en;
        t_addr       restart_ptr;
        bit          dma_en;
        logic [7:0]  cycles_per_line;

        // Sequencer state.
        seq_phase_e  seq_phase;
        t_addr       pc;
        logic [15:0] first_word;
        logic [15:0] second_word;
        bit          skip_armed;
        t_addr       last_fetch;

        t_result     expected_slots[$];
        int          errors;

        function new();
            danger_en       = 1'b0;
            restart_ptr     = '0;
            dma_en          = 1'b0;
            cycles_per_line = LINE_CYCLES_RESET;
            seq_phase       = SEQ_STOP;
            pc              = '0;
            first_word      = '0;
            second_word     = '0;
            skip_armed      = 1'b0;
            last_fetch      = '0;
            errors          = 0;
        endfunction

        // Mirrors one accepted register write.
        function void write_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                CFG_DANGER:  danger_en = value[0];
                CFG_RESTART: restart_ptr = value[20:0];
                CFG_DMA:     dma_en = value[0];
                CFG_LINE:    cycles_per_line = value[7:0];
                default: ;
            endcase
        endfunction

        // Returns the current fetch address and steps the counter by one word.
        function t_addr next_fetch();
            last_fetch = pc;
            pc = pc + t_addr'(2);
            return last_fetch;
        endfunction

        // True once the beam has reached the masked position of the held instruction.
        function bit beam_reached(logic [8:0] line, logic [7:0] cyc);
            logic [7:0] vmask;
            logic [7:0] hmask;
            logic [7:0] line_cmp;
            logic [7:0] target_cmp;
            vmask = {1'b0, second_word[14:8]} | VPOS_FORCE;
            hmask = second_word[7:0] & HPOS_MASK;
            line_cmp = line[7:0] & vmask;
            target_cmp = first_word[15:8] & vmask;
            if (line_cmp > target_cmp) return 1'b1;
            return line_cmp == target_cmp &&
                   (cyc & hmask) >= (first_word[7:0] & HPOS_MASK & hmask);
        endfunction

        // Works out the result of one accepted item and queues it.
        function void note_slot(logic [1:0] req, logic [8:0] line, logic [7:0] cyc,
                                logic [15:0] word, t_addr ptr);
            t_result    r;
            logic [8:0] reg_off;
            bit         legal;
            r = '0;
            if (req == REQ_LOAD || req == REQ_FRAME) begin
                pc = (req == REQ_LOAD) ? ptr : restart_ptr;
                skip_armed = 1'b0;
                seq_phase = SEQ_FIRST;
            end else if (req == REQ_TICK && dma_en &&
                         !(cycles_per_line[0] && cyc == cycles_per_line - 8'd1)) begin
                case (seq_phase)
                    SEQ_FIRST: begin
                        r.fetch_valid = 1'b1;
                        r.fetch_address = next_fetch();
                        seq_phase = SEQ_SECOND;
                    end
                    SEQ_SECOND: begin
                        first_word = word;
                        r.fetch_valid = 1'b1;
                        r.fetch_address = next_fetch();
                        seq_phase = SEQ_EXEC;
                    end
                    SEQ_EXEC: begin
                        second_word = word;
                        if (!first_word[0]) begin
                            // A move: illegal registers stop the program.
                            reg_off = first_word[8:0] & 9'h1fe;
                            legal = reg_off >= REG_MIN_SAFE ||
                                    (reg_off >= REG_MIN_DANGER && danger_en);
                            if (!legal) begin
                                seq_phase = SEQ_STOP;
                                skip_armed = 1'b0;
                            end else begin
                                if (!skip_armed) begin
                                    r.reg_write_valid = 1'b1;
                                    r.reg_address = reg_off;
                                    r.reg_data = second_word;
                                end
                                skip_armed = 1'b0;
                                r.fetch_valid = 1'b1;
                                r.fetch_address = next_fetch();
                                seq_phase = SEQ_SECOND;
                            end
                        end else if (!second_word[0]) begin
                            skip_armed = 1'b0;
                            seq_phase = SEQ_WAIT;
                        end else begin
                            skip_armed = beam_reached(line, cyc);
                            r.fetch_valid = 1'b1;
                            r.fetch_address = next_fetch();
                            seq_phase = SEQ_SECOND;
                        end
                    end
                    SEQ_WAIT: begin
                        if (beam_reached(line, cyc)) begin
                            r.fetch_valid = 1'b1;
                            r.fetch_address = next_fetch();
                            seq_phase = SEQ_SECOND;
                        end
                    end
                    default: ;
                endcase
            end
            r.halted = (seq_phase == SEQ_STOP);
            r.waiting = (seq_phase == SEQ_WAIT);
            expected_slots.push_back(r);
        endfunction

        // Prints one line per mismatch, up to a cap, and counts every one.
        task report_mismatch(string text);
            errors++;
            if (errors <= MAX_PRINTED) $display("mismatch: %s", text);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        endtask

        // Compares one accepted result with the oldest expectation.
        task check_slot_result(t_result got);
            t_result want;
            if (expected_slots.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing expected", got));
                return;
            end
            want = expected_slots.pop_front();
            compare_field("fetch_valid", got.fetch_valid, want.fetch_valid);
            compare_field("fetch_address", got.fetch_address, want.fetch_address);
            compare_field("reg_write_valid", got.reg_write_valid, want.reg_write_valid);
            compare_field("reg_address", got.reg_address, want.reg_address);
            compare_field("reg_data", got.reg_data, want.reg_data);
            compare_field("halted", got.halted, want.halted);
            compare_field("waiting", got.waiting, want.waiting);
        endtask
    endclass

endpackage

@@ tb/tb.sv @@
// Top-level testbench of the display coprocessor: clock, reset, item and register drivers,
// a program memory that answers the block's fetches, and the result side with its stalls.
// Depends on dcmws_pkg, slot_scoreboard_pkg and the display_coprocessor_move_wait_skip RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dcmws_pkg::*;
    import slot_scoreboard_pkg::*;

    // Request code the block ignores.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type = REQ_TICK;
    logic [8:0]  i_beam_line = '0;
    logic [7:0]  i_beam_cycle = '0;
    logic [15:0] i_mem_word = '0;
    logic [20:0] i_new_pointer = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_fetch_valid;
    logic [20:0] o_fetch_address;
    logic        o_reg_write_valid;
    logic [8:0]  o_reg_address;
    logic [15:0] o_reg_data;
    logic        o_halted;
    logic        o_waiting;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_DANGER;
    logic [31:0] i_cfg_data = '0;

    slot_scoreboard sb = new();

    // Program words by address, and the beam position the sender follows.
    logic [15:0] code_mem [int];
    int          beam_line_now = 0;
    int          beam_cycle_now = 0;
    int          wait_ticks = 0;

    // Result side bookkeeping.
    t_result     got;
    int          results_seen = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          rx_mode = 0;
    int          rx_count = 0;

    display_coprocessor_move_wait_skip i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_req_type        (i_req_type),
        .i_beam_line       (i_beam_line),
        .i_beam_cycle      (i_beam_cycle),
        .i_mem_word        (i_mem_word),
        .i_new_pointer     (i_new_pointer),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_fetch_valid     (o_fetch_valid),
        .o_fetch_address   (o_fetch_address),
        .o_reg_write_valid (o_reg_write_valid),
        .o_reg_address     (o_reg_address),
        .o_reg_data        (o_reg_data),
        .o_halted          (o_halted),
        .o_waiting         (o_waiting),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Word that memory returns for the last fetch; unknown addresses read as noise.
    function automatic logic [15:0] word_at(t_addr a);
        if (code_mem.exists(int'(a))) return code_mem[int'(a)];
        return 16'($urandom);
    endfunction

    // Moves the beam forward a few cycles, with an occasional jump anywhere.
    function automatic void advance_beam();
        if ($urandom_range(0, 49) == 0) begin
            beam_line_now = $urandom_range(0, 511);
            beam_cycle_now = $urandom_range(0, 255);
        end else begin
            beam_cycle_now += $urandom_range(1, 3);
            if (beam_cycle_now >= sb.cycles_per_line) begin
                beam_cycle_now = 0;
                beam_line_now = (beam_line_now + 1) % 512;
            end
        end
    endfunction

    // Writes a random program of moves, waits and skips, with positions near the beam.
    function automatic void lay_program(t_addr base, int count);
        t_addr       a;
        logic [15:0] w1;
        logic [15:0] w2;
        int          kind;
        a = base;
        for (int k = 0; k < count; k++) begin
            kind = $urandom_range(0, 99);
            w1 = 16'($urandom);
            w2 = 16'($urandom);
            if (kind < 45) begin
                w1[8:0] = {8'($urandom_range(8'h40, 8'hff)), 1'b0};
            end else if (kind < 55) begin
                w1[8:0] = {8'($urandom_range(8'h20, 8'h3f)), 1'b0};
            end else if (kind < 58) begin
                w1[8:0] = {8'($urandom_range(8'h00, 8'h1f)), 1'b0};
            end else begin
                w1[15:8] = 8'(beam_line_now + $urandom_range(0, 1));
                w1[0] = 1'b1;
                if ($urandom_range(0, 4) != 0) w2[14:1] = '1;
                w2[0] = (kind >= 80);
            end
            code_mem[int'(a)] = w1;
            code_mem[int'(a + t_addr'(2))] = w2;
            a = a + t_addr'(4);
        end
    endfunction

    // Offers one item and waits until it is accepted.
    task automatic send_slot(logic [1:0] req, logic [8:0] line, logic [7:0] cyc,
                             logic [15:0] word, t_addr ptr);
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_beam_line <= line;
        i_beam_cycle <= cyc;
        i_mem_word <= word;
        i_new_pointer <= ptr;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_slot(req, line, cyc, word, ptr);
    endtask

    task automatic tick(logic [8:0] line, logic [7:0] cyc);
        send_slot(REQ_TICK, line, cyc, word_at(sb.last_fetch), t_addr'($urandom));
    endtask

    // Writes one register and waits for the handshake.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_register(idx, value);
    endtask

    // Writes all four registers; unused upper data bits carry noise.
    task automatic write_config(logic danger, t_addr restart, logic dma, logic [7:0] lc);
        write_reg(CFG_DANGER, {31'($urandom), danger});
        write_reg(CFG_RESTART, {11'($urandom), restart});
        write_reg(CFG_DMA, {31'($urandom), dma});
        write_reg(CFG_LINE, {24'($urandom), lc});
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every expected result has come, then a little longer.
    task automatic settle();
        while (sb.expected_slots.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Directed program across the address wrap: move, armed skip, suppressed move,
    // a wait with an ignored odd last cycle, the largest register, then an illegal move.
    task automatic run_directed();
        code_mem[int'(21'h1ffffc)] = 16'h0180;
        code_mem[int'(21'h1ffffe)] = 16'hffff;
        code_mem[int'(21'h000000)] = 16'h0001;
        code_mem[int'(21'h000002)] = 16'hffff;
        code_mem[int'(21'h000004)] = 16'h0182;
        code_mem[int'(21'h000006)] = 16'h1234;
        code_mem[int'(21'h000008)] = 16'h1021;
        code_mem[int'(21'h00000a)] = 16'hfffe;
        code_mem[int'(21'h00000c)] = 16'hfffe;
        code_mem[int'(21'h00000e)] = 16'h0000;
        code_mem[int'(21'h000010)] = 16'h003e;
        code_mem[int'(21'h000012)] = 16'h5a5a;
        send_slot(REQ_UNUSED, 9'h1ff, 8'hff, 16'hffff, 21'h1fffff);
        send_slot(REQ_FRAME, 9'h000, 8'h00, 16'h0000, 21'h000000);
        repeat (9) tick(9'h000, 8'h00);
        tick(9'h00f, 8'hff);
        tick(9'h010, 8'd226);
        tick(9'h010, 8'h1f);
        tick(9'h010, 8'h20);
        repeat (4) tick(9'h010, 8'h21);
        tick(9'h100, 8'h80);
        send_slot(REQ_LOAD, 9'h000, 8'h00, 16'h0000, 21'h1fffff);
        repeat (3) tick(9'h000, 8'h00);
        i_in_valid <= 1'b0;
    endtask

    // Random bursts of items that mostly follow the block's own fetches.
    task automatic run_random(int n_items);
        int          sent;
        int          burst;
        int          gap;
        int          roll;
        logic [1:0]  req;
        logic [15:0] word;
        t_addr       ptr;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 32);
            repeat (burst) begin
                advance_beam();
                roll = $urandom_range(0, 99);
                ptr = t_addr'($urandom);
                if ($urandom_range(0, 7) == 0) ptr = 21'h1fffff - t_addr'($urandom_range(0, 15));
                if ((sb.seq_phase == SEQ_STOP && roll < 40) || wait_ticks > 60 || roll < 3) begin
                    req = $urandom_range(0, 1) ? REQ_LOAD : REQ_FRAME;
                    lay_program(req == REQ_LOAD ? ptr : sb.restart_ptr, $urandom_range(4, 16));
                end else if (roll < 5) begin
                    req = REQ_UNUSED;
                end else begin
                    req = REQ_TICK;
                end
                word = ($urandom_range(0, 9) == 0) ? 16'($urandom) : word_at(sb.last_fetch);
                send_slot(req, 9'(beam_line_now), 8'(beam_cycle_now), word, ptr);
                if (req != REQ_UNUSED) sent++;
                if (sb.seq_phase == SEQ_WAIT) wait_ticks++;
                else wait_ticks = 0;
            end
            // Gaps between bursts, sometimes none so that bursts run together.
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (sent < n_items && gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
    endtask

    // Result side: check accepted results, then choose the next ready value.
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            got.fetch_valid = o_fetch_valid;
            got.fetch_address = o_fetch_address;
            got.reg_write_valid = o_reg_write_valid;
            got.reg_address = o_reg_address;
            got.reg_data = o_reg_data;
            got.halted = o_halted;
            got.waiting = o_waiting;
            sb.check_slot_result(got);
            results_seen++;
        end
        // One long hold-off so that the queue fills and the input side stalls.
        if (!hold_done && results_seen >= 300) begin
            hold_done = 1'b1;
            hold_left = 150;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_count == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_count = $urandom_range(16, 96);
            end
            rx_count--;
            case (rx_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 3) != 0);
                2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= (rx_count % 3 == 0);
            endcase
        end
    end

    // Main sequence: reset, directed program, then random phases under several settings.
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_config(1'b0, 21'h1ffffc, 1'b1, 8'd227);
        run_directed();
        settle();
        write_config(1'b1, 21'h000000, 1'b1, 8'd2);
        run_random(180);
        settle();
        write_config(1'b0, 21'h1fffff, 1'b1, 8'd255);
        run_random(180);
        settle();
        write_config(1'b1, t_addr'($urandom), 1'b0, 8'd9);
        run_random(40);
        settle();
        repeat (5) begin
            write_config(1'($urandom), t_addr'($urandom), 1'b1, 8'($urandom_range(2, 40)));
            run_random(180);
            settle();
        end
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    // Hard limit on the run.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
